FILE: src/sitda_pkg.sv
package sitda_pkg;

  localparam int DD_BITS     = 4;
  localparam int DIGIT_WIDTH = 4;
  localparam int CHAR_WIDTH  = 6;

  localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0]  ASCII_MINUS = 6'd45;
  localparam logic [DIGIT_WIDTH-1:0] DD_LIMIT    = 4'd5;
  localparam logic [DIGIT_WIDTH-1:0] DD_ADJUST   = 4'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic scan;
    logic dec;
    logic sel_sign;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
    logic neg;
    logic idx_zero;
  } dp_status_t;

endpackage

FILE: src/sitda_ctrl.sv
module sitda_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  sitda_pkg::dp_status_t status_i,
  output sitda_pkg::dp_cmd_t    cmd_o
);
  import sitda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = status_i.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
        if (!out_stall_i) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.idx_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.dec = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sitda_dp.sv
module sitda_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [VALUE_BITS-1:0]        value_i,
  input  sitda_pkg::dp_cmd_t                  cmd_i,
  output sitda_pkg::dp_status_t               status_o,
  output logic [sitda_pkg::CHAR_WIDTH-1:0]    char_code_o,
  output logic                                last_o
);
  import sitda_pkg::*;

  localparam int STEPS = (VALUE_BITS + DD_BITS - 1) / DD_BITS;
  localparam int PAD   = STEPS * DD_BITS;
  localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int IDXW  = $clog2(NDIG);
  localparam int CNTW  = $clog2(STEPS);

  logic [PAD-1:0]                     mag_q, mag_d;
  logic [NDIG-1:0][DIGIT_WIDTH-1:0]   bcd_q, bcd_d;
  logic                               neg_q, neg_d;
  logic [CNTW-1:0]                    cnt_q, cnt_d;
  logic [IDXW-1:0]                    idx_q, idx_d;

  logic [VALUE_BITS-1:0]              raw;
  logic [VALUE_BITS-1:0]              mag_in;
  logic [NDIG*DIGIT_WIDTH+PAD-1:0]    work;
  logic [IDXW-1:0]                    top_idx;
  logic [DIGIT_WIDTH-1:0]             cur_digit;

  assign raw    = value_i;
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // shift-add-3, DD_BITS bits per cycle
  always_comb begin
    work = {bcd_q, mag_q};
    for (int s = 0; s < DD_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (work[PAD + DIGIT_WIDTH*d +: DIGIT_WIDTH] >= DD_LIMIT) begin
          work[PAD + DIGIT_WIDTH*d +: DIGIT_WIDTH] =
            work[PAD + DIGIT_WIDTH*d +: DIGIT_WIDTH] + DD_ADJUST;
        end
      end
      work = work << 1;
    end
  end

  // highest nonzero digit, zero maps to index 0
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[d] != '0) begin
        top_idx = IDXW'(d);
      end
    end
  end

  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      mag_d = PAD'(mag_in);
      bcd_d = '0;
      neg_d = raw[VALUE_BITS-1];
      cnt_d = '0;
    end
    if (cmd_i.step) begin
      {bcd_d, mag_d} = work;
      cnt_d          = cnt_q + 1'b1;
    end
    if (cmd_i.scan) begin
      idx_d = top_idx;
    end
    if (cmd_i.dec) begin
      idx_d = idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign cur_digit          = bcd_q[idx_q];
  assign status_o.step_last = (cnt_q == CNTW'(STEPS - 1));
  assign status_o.neg       = neg_q;
  assign status_o.idx_zero  = (idx_q == '0);

  assign char_code_o = cmd_i.sel_sign ? ASCII_MINUS
                                      : ASCII_ZERO + CHAR_WIDTH'(cur_digit);
  assign last_o      = !cmd_i.sel_sign && (idx_q == '0);

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII. Each input transaction carries one
// VALUE_BITS-bit two's complement value; the block returns its decimal text
// one character per output transaction: '-' for negative values, then the
// digits most significant first without leading zeros ("0" for zero), with
// last set on the final character. The most negative value converts exactly.
// One number is handled at a time: the binary-to-BCD shift-add-3 loop runs
// ceil(VALUE_BITS/4) steps, four bits per cycle; then the leading digit is
// found, and characters leave one per cycle from the BCD digit register
// while the output is not stalled.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [VALUE_BITS-1:0]     value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sitda_pkg::CHAR_WIDTH-1:0] char_code_o,
  output logic                             last_o
);
  import sitda_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule
